### sv/ngga_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ngga_pkg;

    // Defaults for the top level parameters
    localparam int MAX_SENTENCE_DEF    = 128;
    localparam int FRACTION_DIGITS_DEF = 5;

    // Field widths on the channels
    localparam int RX_W   = 8;
    localparam int TIME_W = 7;
    localparam int LAT_W  = 31;
    localparam int LON_W  = 32;
    localparam int ALT_W  = 28;
    localparam int SAT_W  = 7;

    // ASCII codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_W      = 8'h57;

    // Comma-separated field numbers of a GGA sentence
    localparam logic [4:0] FLD_TIME = 5'd1;
    localparam logic [4:0] FLD_LAT  = 5'd2;
    localparam logic [4:0] FLD_NS   = 5'd3;
    localparam logic [4:0] FLD_LON  = 5'd4;
    localparam logic [4:0] FLD_EW   = 5'd5;
    localparam logic [4:0] FLD_QUAL = 5'd6;
    localparam logic [4:0] FLD_SATS = 5'd7;
    localparam logic [4:0] FLD_ALT  = 5'd9;
    localparam logic [4:0] FLD_LAST = 5'd31;

    // Header byte positions ('$' is position 0)
    localparam logic [7:0] POS_HDR_G1 = 8'd3;
    localparam logic [7:0] POS_HDR_G2 = 8'd4;
    localparam logic [7:0] POS_HDR_A  = 8'd5;

    // Hemisphere codes, two bits per axis
    localparam logic [1:0] HEM_UNKNOWN = 2'd0;
    localparam logic [1:0] HEM_POS     = 2'd1;
    localparam logic [1:0] HEM_NEG     = 2'd2;

    localparam logic [19:0] INT_LIMIT     = 20'd999999;
    localparam logic [26:0] ALT_POS_LIMIT = 27'd99999999;
    localparam logic [26:0] ALT_NEG_LIMIT = 27'd1000000;
    localparam logic [37:0] LAT_LIMIT     = 38'd900000000;
    localparam logic [37:0] LON_LIMIT     = 38'd1800000000;
    localparam logic [23:0] E7            = 24'd10000000;
    localparam logic [2:0]  TIME_DIGITS   = 3'd6;
    localparam logic [2:0]  COUNT_MAX     = 3'd7;
    localparam logic [2:0]  ALT_FRAC_MAX  = 3'd2;

    // Reciprocals: floor(x/100) = (x*R100)>>27 for x < 2^20,
    // floor(y/60) = (y*R60)>>37 for y < 2^30
    localparam logic [20:0] RECIP100 = 21'd1342178;
    localparam logic [31:0] RECIP60  = 32'd2290649225;

    typedef enum logic [2:0] {
        CONV_IDLE,
        CONV_DEG,
        CONV_SPLIT,
        CONV_SUM,
        CONV_DIV,
        CONV_OUT
    } conv_state_t;

    function automatic logic [23:0] pow10(input logic [2:0] n);
        logic [23:0] r;
        unique case (n)
            3'd0:    r = 24'd1;
            3'd1:    r = 24'd10;
            3'd2:    r = 24'd100;
            3'd3:    r = 24'd1000;
            3'd4:    r = 24'd10000;
            3'd5:    r = 24'd100000;
            3'd6:    r = 24'd1000000;
            default: r = 24'd10000000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/ngga_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ngga_in_if;
    import ngga_pkg::*;

    logic            valid;
    logic            ready;
    logic [RX_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### sv/ngga_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ngga_out_if;
    import ngga_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    fix_valid;
    logic [TIME_W-1:0]       utc_hours;
    logic [TIME_W-1:0]       utc_minutes;
    logic [TIME_W-1:0]       utc_seconds;
    logic signed [LAT_W-1:0] latitude_e7;
    logic signed [LON_W-1:0] longitude_e7;
    logic signed [ALT_W-1:0] altitude_cm;
    logic [SAT_W-1:0]        satellites;

    modport source (output valid, output fix_valid, output utc_hours, output utc_minutes,
                    output utc_seconds, output latitude_e7, output longitude_e7,
                    output altitude_cm, output satellites, input ready);
    modport sink   (input valid, input fix_valid, input utc_hours, input utc_minutes,
                    input utc_seconds, input latitude_e7, input longitude_e7,
                    input altitude_cm, input satellites, output ready);
endinterface

`default_nettype wire

### sv/nmea_gga_sentence_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// NMEA 0183 GGA parser. One ASCII byte per request on in_ch, one request per clock
// cycle sustained. Bytes outside a sentence are dropped; '$' opens (or reopens) a
// sentence, and a carriage return closing a GGA sentence yields one request on out_ch
// carrying time, latitude/longitude in degrees x1e7, altitude in cm and satellite
// count (all zero with fix_valid low unless the quality field reads '1' or '2').
// The result is registered at the end of the coordinate conversion, which
// runs through a five-step sequencer (split off degrees, scale minutes,
// divide by 60 with a reciprocal multiply, saturate and sign). Bytes keep flowing
// during the conversion; in_ch.ready drops only while a finished result is held
// back by out_ch and the output register is still full.
module nmea_gga_sentence_parser
    import ngga_pkg::*;
#(
    parameter int MAX_SENTENCE    = MAX_SENTENCE_DEF,
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    ngga_in_if.sink    in_ch,
    ngga_out_if.source out_ch
);

    localparam int          FRAC_W      = $clog2(10 ** FRACTION_DIGITS);
    localparam int          FRAC_SCALE  = 10 ** (7 - FRACTION_DIGITS);
    localparam logic [7:0]  POS_LIMIT   = 8'(MAX_SENTENCE);
    localparam logic [2:0]  FRAC_DIGITS = 3'(FRACTION_DIGITS);

    // ---------------------------------------------------------------
    // Sentence scanner state
    // ---------------------------------------------------------------
    logic              in_sentence_reg, in_sentence_next;
    logic [7:0]        byte_pos_reg, byte_pos_next;
    logic [4:0]        field_reg, field_next;
    logic [2:0]        header_reg, header_next;
    logic [23:0]       time_reg, time_next;          // six BCD digits
    logic [19:0]       ip_reg [2];                   // lane 0 latitude, lane 1 longitude
    logic [19:0]       ip_next [2];
    logic [FRAC_W-1:0] fp_reg [2];
    logic [FRAC_W-1:0] fp_next [2];
    logic [2:0]        count_reg, count_next;
    logic              in_frac_reg, in_frac_next;
    logic [3:0]        hem_reg, hem_next;
    logic [7:0]        quality_reg, quality_next;
    logic [6:0]        sat_reg, sat_next;
    logic [26:0]       alt_reg, alt_next;
    logic              alt_neg_reg, alt_neg_next;

    logic              accept;
    logic              launch;
    logic [7:0]        c;
    logic              is_digit;
    logic [3:0]        d;
    logic              lane;
    logic [23:0]       ip_mac;
    logic [FRAC_W+3:0] fp_mac;
    logic [47:0]       fp_pad;
    logic [10:0]       sat_mac;
    logic [30:0]       alt_mac;

    assign accept   = in_ch.valid && in_ch.ready;
    assign c        = in_ch.rx_byte;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign d        = 4'(c - CH_ZERO);
    assign lane     = (field_reg == FLD_LON);
    assign ip_mac   = 24'(ip_reg[lane]) * 24'd10 + 24'(d);
    assign fp_mac   = (FRAC_W+4)'(fp_reg[lane]) * (FRAC_W+4)'(10) + (FRAC_W+4)'(d);
    assign fp_pad   = 48'(fp_reg[lane]) * 48'(pow10(FRAC_DIGITS - count_reg));
    assign sat_mac  = 11'(sat_reg) * 11'd10 + 11'(d);

    always_comb
    begin
        if (!in_frac_reg)
        begin
            alt_mac = 31'(alt_reg) * 31'd10 + 31'(d) * 31'd100;
        end
        else if (count_reg == 3'd0)
        begin
            alt_mac = 31'(alt_reg) + 31'(d) * 31'd10;
        end
        else
        begin
            alt_mac = 31'(alt_reg) + 31'(d);
        end
    end

    always_comb
    begin
        in_sentence_next = in_sentence_reg;
        byte_pos_next    = byte_pos_reg;
        field_next       = field_reg;
        header_next      = header_reg;
        time_next        = time_reg;
        ip_next          = ip_reg;
        fp_next          = fp_reg;
        count_next       = count_reg;
        in_frac_next     = in_frac_reg;
        hem_next         = hem_reg;
        quality_next     = quality_reg;
        sat_next         = sat_reg;
        alt_next         = alt_reg;
        alt_neg_next     = alt_neg_reg;
        launch           = 1'b0;

        if (accept)
        begin
            if (c == CH_DOLLAR)
            begin
                in_sentence_next = 1'b1;
                byte_pos_next    = 8'd1;
                field_next       = '0;
                header_next      = '0;
                time_next        = '0;
                ip_next[0]       = '0;
                ip_next[1]       = '0;
                fp_next[0]       = '0;
                fp_next[1]       = '0;
                count_next       = '0;
                in_frac_next     = 1'b0;
                hem_next         = '0;
                quality_next     = CH_ZERO;
                sat_next         = '0;
                alt_next         = '0;
                alt_neg_next     = 1'b0;
            end
            else if (in_sentence_reg)
            begin
                if (c == CH_CR)
                begin
                    in_sentence_next = 1'b0;
                    launch           = (header_reg == 3'b111);
                end
                else if (byte_pos_reg >= POS_LIMIT)
                begin
                    in_sentence_next = 1'b0;   // over-long sentence dropped
                end
                else
                begin
                    if (byte_pos_reg == POS_HDR_G1 && c == CH_G) header_next[0] = 1'b1;
                    if (byte_pos_reg == POS_HDR_G2 && c == CH_G) header_next[1] = 1'b1;
                    if (byte_pos_reg == POS_HDR_A  && c == CH_A) header_next[2] = 1'b1;
                    byte_pos_next = byte_pos_reg + 8'd1;

                    if (c == CH_COMMA)
                    begin
                        if (field_reg == FLD_LAT || field_reg == FLD_LON)
                        begin
                            fp_next[lane] = FRAC_W'(fp_pad);
                        end
                        if (field_reg < FLD_LAST) field_next = field_reg + 5'd1;
                        count_next   = '0;
                        in_frac_next = 1'b0;
                    end
                    else
                    begin
                        unique case (field_reg)
                            FLD_TIME:
                            begin
                                if (is_digit && !in_frac_reg && count_reg < TIME_DIGITS)
                                begin
                                    for (int k = 0; k < 6; k++)
                                    begin
                                        if (count_reg == 3'(k)) time_next[20-4*k +: 4] = d;
                                    end
                                    count_next = count_reg + 3'd1;
                                end
                                else if (c == CH_DOT) in_frac_next = 1'b1;
                            end
                            FLD_LAT, FLD_LON:
                            begin
                                if (is_digit)
                                begin
                                    if (!in_frac_reg)
                                    begin
                                        ip_next[lane] = (ip_mac > 24'(INT_LIMIT)) ?
                                                        INT_LIMIT : 20'(ip_mac);
                                    end
                                    else if (count_reg < FRAC_DIGITS)
                                    begin
                                        fp_next[lane] = FRAC_W'(fp_mac);
                                        count_next    = count_reg + 3'd1;
                                    end
                                end
                                else if (c == CH_DOT) in_frac_next = 1'b1;
                            end
                            FLD_NS, FLD_EW, FLD_QUAL:
                            begin
                                if (count_reg == 3'd0)
                                begin
                                    if (field_reg == FLD_NS)
                                    begin
                                        hem_next[1:0] = (c == CH_N) ? HEM_POS :
                                                        (c == CH_S) ? HEM_NEG : HEM_UNKNOWN;
                                    end
                                    else if (field_reg == FLD_EW)
                                    begin
                                        hem_next[3:2] = (c == CH_E) ? HEM_POS :
                                                        (c == CH_W) ? HEM_NEG : HEM_UNKNOWN;
                                    end
                                    else
                                    begin
                                        quality_next = c;
                                    end
                                end
                                if (count_reg < COUNT_MAX) count_next = count_reg + 3'd1;
                            end
                            FLD_SATS:
                            begin
                                if (is_digit && !in_frac_reg)
                                begin
                                    sat_next = (sat_mac > 11'd99) ? 7'd99 : 7'(sat_mac);
                                end
                                else if (c == CH_DOT) in_frac_next = 1'b1;
                            end
                            FLD_ALT:
                            begin
                                if (is_digit)
                                begin
                                    if (!in_frac_reg || count_reg < ALT_FRAC_MAX)
                                    begin
                                        alt_next = (alt_mac > 31'(ALT_POS_LIMIT)) ?
                                                   ALT_POS_LIMIT : 27'(alt_mac);
                                    end
                                    if (in_frac_reg && count_reg < ALT_FRAC_MAX)
                                    begin
                                        count_next = count_reg + 3'd1;
                                    end
                                end
                                else if (c == CH_DOT) in_frac_next = 1'b1;
                                else if (c == CH_MINUS && !in_frac_reg) alt_neg_next = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sentence_reg <= 1'b0;
            byte_pos_reg    <= '0;
            field_reg       <= '0;
            header_reg      <= '0;
            time_reg        <= '0;
            ip_reg[0]       <= '0;
            ip_reg[1]       <= '0;
            fp_reg[0]       <= '0;
            fp_reg[1]       <= '0;
            count_reg       <= '0;
            in_frac_reg     <= 1'b0;
            hem_reg         <= '0;
            quality_reg     <= CH_ZERO;
            sat_reg         <= '0;
            alt_reg         <= '0;
            alt_neg_reg     <= 1'b0;
        end
        else
        begin
            in_sentence_reg <= in_sentence_next;
            byte_pos_reg    <= byte_pos_next;
            field_reg       <= field_next;
            header_reg      <= header_next;
            time_reg        <= time_next;
            ip_reg          <= ip_next;
            fp_reg          <= fp_next;
            count_reg       <= count_next;
            in_frac_reg     <= in_frac_next;
            hem_reg         <= hem_next;
            quality_reg     <= quality_next;
            sat_reg         <= sat_next;
            alt_reg         <= alt_next;
            alt_neg_reg     <= alt_neg_next;
        end
    end

    // ---------------------------------------------------------------
    // Conversion sequencer; the snapshot taken at the carriage return
    // leaves the scanner free for the next sentence
    // ---------------------------------------------------------------
    conv_state_t       state_reg, state_next;
    logic              done;

    logic              cv_fix_reg;
    logic [TIME_W-1:0] cv_hours_reg, cv_minutes_reg, cv_seconds_reg;
    logic [ALT_W-1:0]  cv_alt_reg;
    logic [SAT_W-1:0]  cv_sat_reg;
    logic [3:0]        cv_hem_reg;
    logic [19:0]       cv_ip_reg [2];
    logic [FRAC_W-1:0] cv_fp_reg [2];
    logic [13:0]       cv_deg_reg [2];
    logic [6:0]        cv_mm_reg [2];
    logic [36:0]       cv_dege7_reg [2];
    logic [29:0]       cv_y_reg [2];
    logic [24:0]       cv_q_reg [2];

    logic [ALT_W-1:0]  snap_alt;
    logic [26:0]       alt_clip;
    logic [40:0]       deg_prod [2];
    logic [19:0]       mm_full [2];
    logic [61:0]       q_prod [2];
    logic [37:0]       sum [2];
    logic [31:0]       mag [2];
    logic [31:0]       coord [2];
    logic [1:0]        hem_lane [2];

    logic signed [31:0] last_reg [2];

    logic              out_valid_reg;
    logic              out_fix_reg;
    logic [TIME_W-1:0] out_hours_reg, out_minutes_reg, out_seconds_reg;
    logic [LAT_W-1:0]  out_lat_reg;
    logic [LON_W-1:0]  out_lon_reg;
    logic [ALT_W-1:0]  out_alt_reg;
    logic [SAT_W-1:0]  out_sat_reg;

    assign alt_clip = (alt_reg > ALT_NEG_LIMIT) ? ALT_NEG_LIMIT : alt_reg;
    assign snap_alt = alt_neg_reg ? -ALT_W'(alt_clip) : ALT_W'(alt_reg);
    assign hem_lane[0] = cv_hem_reg[1:0];
    assign hem_lane[1] = cv_hem_reg[3:2];

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            deg_prod[i] = 41'(cv_ip_reg[i]) * 41'(RECIP100);
            mm_full[i]  = cv_ip_reg[i] - 20'(cv_deg_reg[i]) * 20'd100;
            q_prod[i]   = 62'(cv_y_reg[i]) * 62'(RECIP60);
            sum[i]      = 38'(cv_dege7_reg[i]) + 38'(cv_q_reg[i]);
            if (i == 0)
            begin
                mag[i] = (sum[i] > LAT_LIMIT) ? 32'(LAT_LIMIT) : 32'(sum[i]);
            end
            else
            begin
                mag[i] = (sum[i] > LON_LIMIT) ? 32'(LON_LIMIT) : 32'(sum[i]);
            end
            if (!cv_fix_reg)
            begin
                coord[i] = '0;
            end
            else if (hem_lane[i] == HEM_POS)
            begin
                coord[i] = mag[i];
            end
            else if (hem_lane[i] == HEM_NEG)
            begin
                coord[i] = -mag[i];
            end
            else
            begin
                coord[i] = last_reg[i];   // unknown hemisphere repeats the last coordinate output
            end
        end
    end

    assign done = (state_reg == CONV_OUT) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CONV_IDLE:  if (launch) state_next = CONV_DEG;
            CONV_DEG:   state_next = CONV_SPLIT;
            CONV_SPLIT: state_next = CONV_SUM;
            CONV_SUM:   state_next = CONV_DIV;
            CONV_DIV:   state_next = CONV_OUT;
            CONV_OUT:   if (done) state_next = launch ? CONV_DEG : CONV_IDLE;
            default:    state_next = CONV_IDLE;
        endcase
    end

    // Input stalls only when a finished result cannot leave
    always_comb
    begin
        in_ch.ready = !((state_reg == CONV_OUT) && out_valid_reg && !out_ch.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CONV_IDLE;
            out_valid_reg <= 1'b0;
            last_reg[0]   <= '0;
            last_reg[1]   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (done)
            begin
                out_valid_reg <= 1'b1;
                last_reg[0]   <= coord[0];
                last_reg[1]   <= coord[1];
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (launch)
        begin
            cv_fix_reg     <= (quality_reg == CH_ONE) || (quality_reg == CH_TWO);
            cv_hours_reg   <= TIME_W'(time_reg[23:20]) * TIME_W'(10) + TIME_W'(time_reg[19:16]);
            cv_minutes_reg <= TIME_W'(time_reg[15:12]) * TIME_W'(10) + TIME_W'(time_reg[11:8]);
            cv_seconds_reg <= TIME_W'(time_reg[7:4]) * TIME_W'(10) + TIME_W'(time_reg[3:0]);
            cv_alt_reg     <= snap_alt;
            cv_sat_reg     <= sat_reg;
            cv_hem_reg     <= hem_reg;
            cv_ip_reg      <= ip_reg;
            cv_fp_reg      <= fp_reg;
        end
        for (int i = 0; i < 2; i++)
        begin
            if (state_reg == CONV_DEG)
            begin
                cv_deg_reg[i] <= deg_prod[i][40:27];
            end
            if (state_reg == CONV_SPLIT)
            begin
                cv_mm_reg[i]    <= 7'(mm_full[i]);
                cv_dege7_reg[i] <= 37'(cv_deg_reg[i]) * 37'(E7);
            end
            if (state_reg == CONV_SUM)
            begin
                cv_y_reg[i] <= 30'(cv_mm_reg[i]) * 30'(E7) + 30'(cv_fp_reg[i]) * 30'(FRAC_SCALE);
            end
            if (state_reg == CONV_DIV)
            begin
                cv_q_reg[i] <= q_prod[i][61:37];
            end
        end
        if (done)
        begin
            out_fix_reg     <= cv_fix_reg;
            out_hours_reg   <= cv_fix_reg ? cv_hours_reg : '0;
            out_minutes_reg <= cv_fix_reg ? cv_minutes_reg : '0;
            out_seconds_reg <= cv_fix_reg ? cv_seconds_reg : '0;
            out_lat_reg     <= coord[0][LAT_W-1:0];
            out_lon_reg     <= coord[1];
            out_alt_reg     <= cv_fix_reg ? cv_alt_reg : '0;
            out_sat_reg     <= cv_fix_reg ? cv_sat_reg : '0;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.fix_valid    = out_fix_reg;
    assign out_ch.utc_hours    = out_hours_reg;
    assign out_ch.utc_minutes  = out_minutes_reg;
    assign out_ch.utc_seconds  = out_seconds_reg;
    assign out_ch.latitude_e7  = out_lat_reg;
    assign out_ch.longitude_e7 = out_lon_reg;
    assign out_ch.altitude_cm  = out_alt_reg;
    assign out_ch.satellites   = out_sat_reg;

endmodule

`default_nettype wire
